// ===== rtl/core/bss_pkg.sv =====
// Package with shared types and constants of the bundle slot store.
`default_nettype none
package bss_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned CntW = 5;

  typedef enum logic [1:0] {
    ACT_SAVE   = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_DUP     = 3'd1,
    ST_EVICTED = 3'd2,
    ST_DELETED = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_TICK    = 3'd5,
    ST_CLEARED = 3'd6
  } status_e;

  localparam logic [15:0] StepReset = 16'd5;
  localparam logic [15:0] ExpireReset = 16'd6;
  localparam logic [2:0] AddrStep = 3'd0;
  localparam logic [2:0] AddrExpire = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] source_node;
    logic [31:0] creation_time;
    logic [31:0] sequence_number;
    logic [31:0] fragment_offset;
    logic [15:0] bundle_size;
    logic [31:0] bundle_lifetime;
    logic [3:0]  target_slot;
  } in_item_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [2:0] status;
    logic [4:0] expired_count;
    logic [4:0] free_slots;
    logic [4:0] stored_count;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;      // capture input item, reset scan
    logic       scan;      // process slot at scan index
    logic       commit;    // apply save/delete/clear result
    logic       last_slot; // scan index is last slot
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic dup_found;
    logic last;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/bss_if.sv =====
// Valid/ready channel interfaces for input and result items.
`default_nettype none
interface bss_in_if;
  import bss_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bss_out_if;
  import bss_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bss_ctrl.sv =====
// Controller state machine sequencing the slot scan of one item.
`default_nettype none
module bss_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_busy_i,
  input  wire bss_pkg::stat_t stat_i,
  output bss_pkg::cmd_t      cmd_o
);
  import bss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        cmd_o.last_slot = stat_i.last;
        // A duplicate stops the scan early; the table stays untouched.
        if (stat_i.last || stat_i.dup_found) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_busy_i) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ===== rtl/core/bss_datapath.sv =====
// Slot table registers, scan index and result formation.
`default_nettype none
module bss_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bss_pkg::in_item_t in_data_i,
  input  wire bss_pkg::cmd_t     cmd_i,
  input  wire logic [15:0]       step_i,
  input  wire logic [15:0]       expire_i,
  output bss_pkg::stat_t         stat_o,
  output bss_pkg::out_item_t     result_o
);
  import bss_pkg::*;

  logic [15:0] size_q [Slots];
  logic [31:0] life_q [Slots];
  logic [31:0] src_q  [Slots];
  logic [31:0] tim_q  [Slots];
  logic [31:0] seq_q  [Slots];
  logic [31:0] frag_q [Slots];
  logic [CntW-1:0] occ_q;

  in_item_t        item_q;
  logic [SlotW-1:0] idx_q;
  logic            have_free_q, dup_q, have_min_q;
  logic [SlotW-1:0] free_q, dup_idx_q, min_idx_q;
  logic [31:0]     min_life_q;
  logic [CntW-1:0] exp_q;

  logic        occ_i, match_i;
  logic [31:0] life_i;

  assign occ_i = size_q[idx_q] != 16'd0;
  assign life_i = life_q[idx_q];
  assign match_i = occ_i && src_q[idx_q] == item_q.source_node
                && tim_q[idx_q] == item_q.creation_time
                && seq_q[idx_q] == item_q.sequence_number
                && frag_q[idx_q] == item_q.fragment_offset;

  assign stat_o.last = idx_q == SlotW'(Slots - 1);
  assign stat_o.dup_found = action_e'(item_q.action) == ACT_SAVE && match_i;

  logic            save_new;
  logic [SlotW-1:0] save_idx;
  assign save_new = !dup_q;
  assign save_idx = have_free_q ? free_q : min_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        size_q[i] <= '0;
        life_q[i] <= '0;
      end
      occ_q <= '0;
      idx_q <= '0;
      have_free_q <= 1'b0;
      dup_q <= 1'b0;
      have_min_q <= 1'b0;
      free_q <= '0;
      dup_idx_q <= '0;
      min_idx_q <= '0;
      min_life_q <= '0;
      exp_q <= '0;
      result_o <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
      have_free_q <= 1'b0;
      dup_q <= 1'b0;
      have_min_q <= 1'b0;
      exp_q <= '0;
    end else if (cmd_i.scan) begin
      if (!cmd_i.last_slot) idx_q <= idx_q + 1'b1;
      case (action_e'(item_q.action))
        ACT_SAVE: begin
          if (!occ_i) begin
            if (!have_free_q) begin
              have_free_q <= 1'b1;
              free_q <= idx_q;
            end
          end else if (match_i) begin
            dup_q <= 1'b1;
            dup_idx_q <= idx_q;
          end else if (!have_min_q || life_i < min_life_q) begin
            have_min_q <= 1'b1;
            min_life_q <= life_i;
            min_idx_q <= idx_q;
          end
        end
        ACT_TICK: begin
          if (occ_i) begin
            if (life_i < {16'd0, expire_i}) begin
              size_q[idx_q] <= '0;
              life_q[idx_q] <= '0;
              exp_q <= exp_q + 1'b1;
              occ_q <= occ_q - 1'b1;
            end else if (life_i < {16'd0, step_i}) begin
              life_q[idx_q] <= '0;
            end else begin
              life_q[idx_q] <= life_i - {16'd0, step_i};
            end
          end
        end
        default: ;
      endcase
    end else if (cmd_i.commit) begin
      result_o.expired_count <= '0;
      result_o.slot <= '0;
      result_o.free_slots <= CntW'(Slots) - occ_q;
      result_o.stored_count <= occ_q;
      case (action_e'(item_q.action))
        ACT_SAVE: begin
          if (!save_new) begin
            result_o.slot <= dup_idx_q;
            result_o.status <= ST_DUP;
          end else begin
            size_q[save_idx] <= (item_q.bundle_size == 16'd0) ? 16'd1
                                : item_q.bundle_size;
            life_q[save_idx] <= item_q.bundle_lifetime;
            src_q[save_idx] <= item_q.source_node;
            tim_q[save_idx] <= item_q.creation_time;
            seq_q[save_idx] <= item_q.sequence_number;
            frag_q[save_idx] <= item_q.fragment_offset;
            result_o.slot <= save_idx;
            result_o.status <= have_free_q ? ST_NEW : ST_EVICTED;
            if (have_free_q) begin
              occ_q <= occ_q + 1'b1;
              result_o.free_slots <= CntW'(Slots) - occ_q - 1'b1;
              result_o.stored_count <= occ_q + 1'b1;
            end
          end
        end
        ACT_TICK: begin
          result_o.status <= ST_TICK;
          result_o.expired_count <= exp_q;
        end
        ACT_DELETE: begin
          result_o.slot <= item_q.target_slot;
          if (size_q[item_q.target_slot] != 16'd0) begin
            size_q[item_q.target_slot] <= '0;
            life_q[item_q.target_slot] <= '0;
            occ_q <= occ_q - 1'b1;
            result_o.status <= ST_DELETED;
            result_o.free_slots <= CntW'(Slots) - occ_q + 1'b1;
            result_o.stored_count <= occ_q - 1'b1;
          end else begin
            result_o.status <= ST_EMPTY;
          end
        end
        default: begin
          for (int i = 0; i < Slots; i++) begin
            size_q[i] <= '0;
            life_q[i] <= '0;
          end
          occ_q <= '0;
          result_o.status <= ST_CLEARED;
          result_o.free_slots <= CntW'(Slots);
          result_o.stored_count <= '0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/bundle_slot_store_with_expiry.sv =====
// Top level of the bundle slot store with lifetime expiry.
// Each item walks the 16 slots one per cycle through a single compare and
// subtract unit: a load step, the slot scan (cut short for a save that hits
// a duplicate), and a commit step that waits while the output is stalled.
// The result register holds the result while it waits; the next item is
// accepted once the result is committed.
// Registers: 0x0 lifetime_step, 0x4 expire_below, both 16 bits.
`default_nettype none
module bundle_slot_store_with_expiry (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bss_in_if.sink           in_ch,
  bss_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bss_pkg::*;

  logic [15:0] step_q, expire_q;
  cmd_t        cmd;
  stat_t       stat;
  out_item_t   result;
  logic        out_valid_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepReset;
      expire_q <= ExpireReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrStep) step_q <= pwdata[15:0];
      else if (paddr == AddrExpire) expire_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == AddrStep) prdata = {16'd0, step_q};
    else if (paddr == AddrExpire) prdata = {16'd0, expire_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd.commit) out_valid_q <= 1'b1;
    else if (out_ch.ready) out_valid_q <= 1'b0;
  end

  bss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .out_busy_i (out_valid_q && !out_ch.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bss_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_ch.data),
    .cmd_i     (cmd),
    .step_i    (step_q),
    .expire_i  (expire_q),
    .stat_o    (stat),
    .result_o  (result)
  );

  assign out_ch.valid = out_valid_q;
  assign out_ch.data = result;
endmodule
`default_nettype wire

// ===== rtl/core/bss_checker.sv =====
// Port-level checker for the bundle slot store, bound to the top level.
`default_nettype none
module bss_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] status_i,
  input wire logic [4:0] free_slots_i,
  input wire logic [4:0] stored_count_i,
  input wire logic [4:0] expired_count_i
);
  import bss_pkg::*;

  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (free_slots_i + stored_count_i) == 5'(Slots))
    else $error("free and stored counts do not add up");

  a_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != ST_TICK) |-> expired_count_i == 5'd0)
    else $error("expired count outside tick");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("second item accepted during work");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(status_i))
    else $error("stalled result changed");
endmodule

bind bundle_slot_store_with_expiry bss_checker u_bss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .status_i        (out_ch.data.status),
  .free_slots_i    (out_ch.data.free_slots),
  .stored_count_i  (out_ch.data.stored_count),
  .expired_count_i (out_ch.data.expired_count)
);
`default_nettype wire
